// ----- src/lpr_pkg.sv -----
// Shared types and constants for the line pixel rasterizer.
// No dependencies; used by lpr_stepper and line_pixel_rasterizer.
`default_nettype none

package lpr_pkg;

   localparam int COORD_BITS = 11;
   localparam int COLOR_BITS = 32;

   // Payload widths on the stream ports, rounded up to whole bytes
   localparam int REQ_FIELD_BITS = 4 * COORD_BITS + COLOR_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COLOR_BITS-1:0] color_type;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_ADVANCE = 1'b1
   } opcode_type;

   // One accepted request beat, unpacked
   typedef struct packed {
      opcode_type opcode;
      coord_type  start_x;
      coord_type  start_y;
      coord_type  end_x;
      coord_type  end_y;
      color_type  color;
   } req_item_type;

   // One pixel result
   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      color_type pixel_color;
      logic      last_pixel;
   } pixel_type;

endpackage

`default_nettype wire

// ----- src/line_pixel_rasterizer.sv -----
// Top level of the line pixel rasterizer: request register, stepper, result register.
// Depends on lpr_pkg and lpr_stepper.
//
// Rasterizes one line at a time. A load beat (tuser = 0) latches start point,
// end point and color and yields no result; each advance beat (tuser = 1)
// yields the next pixel, stepping one unit along the major axis (x when
// |dx| > |dy|, y otherwise) with the minor coordinate tracked exactly by a
// running quotient and remainder. The end point is not drawn, a zero-length
// line draws nothing, and the final pixel carries rsp_tlast. Advance beats
// with no line in progress are consumed silently. Every beat passes through the
// request register and then the result register, with the combinational stepper
// update between the two; one beat is taken per clock while the result register
// is empty or rsp_tready is high.
`default_nettype none

module line_pixel_rasterizer (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // start_x, start_y, end_x, end_y, color, zero pad
   input  wire  [lpr_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // opcode
   input  wire                                req_tuser,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // pixel_x, pixel_y, pixel_color, zero pad
   output logic [lpr_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                               rsp_tlast
);

   localparam int CB = lpr_pkg::COORD_BITS;

   logic                  in_valid_ff, in_valid_in;
   lpr_pkg::req_item_type in_item_ff, in_item_in;
   logic                  out_valid_ff, out_valid_in;
   lpr_pkg::pixel_type    out_pix_ff, out_pix_in;
   logic                  step_en;
   logic                  pix_valid;
   lpr_pkg::pixel_type    pix;

   // Advance the request register whenever the result slot is free or draining
   always_comb begin
      step_en    = in_valid_ff && (!out_valid_ff || rsp_tready);
      req_tready = !in_valid_ff || step_en;
   end

   // Unpack an incoming beat
   always_comb begin
      in_item_in.opcode  = lpr_pkg::opcode_type'(req_tuser);
      in_item_in.start_x = req_tdata[CB-1:0];
      in_item_in.start_y = req_tdata[2*CB-1:CB];
      in_item_in.end_x   = req_tdata[3*CB-1:2*CB];
      in_item_in.end_y   = req_tdata[4*CB-1:3*CB];
      in_item_in.color   = req_tdata[4*CB+lpr_pkg::COLOR_BITS-1:4*CB];
      in_valid_in        = (req_tvalid && req_tready) || (in_valid_ff && !step_en);
   end

   lpr_stepper u_stepper (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .item      (in_item_ff),
      .pix_valid (pix_valid),
      .pix       (pix)
   );

   // Result slot: fill on a pixel, clear when taken
   always_comb begin
      out_pix_in = out_pix_ff;
      if (step_en) begin
         out_valid_in = pix_valid;
         out_pix_in   = pix;
      end else begin
         out_valid_in = out_valid_ff && !rsp_tready;
      end
   end

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_item_ff <= in_item_in;
      end
      out_pix_ff <= out_pix_in;
   end

   // Pack the result beat
   always_comb begin
      rsp_tvalid = out_valid_ff;
      rsp_tdata  = lpr_pkg::RSP_DATA_BITS'({out_pix_ff.pixel_color,
                                            out_pix_ff.pixel_y,
                                            out_pix_ff.pixel_x});
      rsp_tlast  = out_pix_ff.last_pixel;
   end

endmodule

`default_nettype wire

// ----- src/lpr_stepper.sv -----
// Line state and per-beat stepping for the line pixel rasterizer.
// Depends on lpr_pkg. Loads a line on OP_LOAD, emits one pixel per OP_ADVANCE while a line is active.
`default_nettype none

module lpr_stepper (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   step_en,
   input  lpr_pkg::req_item_type item,
   output logic                  pix_valid,
   output lpr_pkg::pixel_type    pix
);

   // Line state
   lpr_pkg::coord_type origin_x_ff, origin_x_in;
   lpr_pkg::coord_type origin_y_ff, origin_y_in;
   lpr_pkg::coord_type major_len_ff, major_len_in;
   lpr_pkg::coord_type minor_mag_ff, minor_mag_in;
   lpr_pkg::coord_type step_ff, step_in;
   lpr_pkg::coord_type quot_ff, quot_in;
   lpr_pkg::coord_type rem_ff, rem_in;
   logic               major_is_x_ff, major_is_x_in;
   logic               major_neg_ff, major_neg_in;
   logic               minor_neg_ff, minor_neg_in;
   lpr_pkg::color_type color_ff, color_in;
   logic               active_ff, active_in;

   // Load setup
   logic               x_neg, y_neg, x_major;
   lpr_pkg::coord_type abs_dx, abs_dy, ld_major_len;

   // Step datapath
   lpr_pkg::coord_type             minor_amt, major_base, minor_base;
   lpr_pkg::coord_type             major_c, minor_c;
   logic [lpr_pkg::COORD_BITS:0]   step_next, rem_sum;
   logic                           last;
   logic                           emit;

   // Endpoint deltas and axis choice; equal deltas pick y as major
   always_comb begin
      x_neg        = item.end_x < item.start_x;
      y_neg        = item.end_y < item.start_y;
      abs_dx       = x_neg ? item.start_x - item.end_x : item.end_x - item.start_x;
      abs_dy       = y_neg ? item.start_y - item.end_y : item.end_y - item.start_y;
      x_major      = abs_dx > abs_dy;
      ld_major_len = x_major ? abs_dx : abs_dy;
   end

   // Pixel coordinates from the running quotient; round the magnitude up
   // on a negative minor delta so the coordinate stays the floor
   always_comb begin
      minor_amt  = quot_ff + lpr_pkg::COORD_BITS'(minor_neg_ff && (rem_ff != '0));
      major_base = major_is_x_ff ? origin_x_ff : origin_y_ff;
      minor_base = major_is_x_ff ? origin_y_ff : origin_x_ff;
      major_c    = major_neg_ff ? major_base - step_ff : major_base + step_ff;
      minor_c    = minor_neg_ff ? minor_base - minor_amt : minor_base + minor_amt;
      step_next  = {1'b0, step_ff} + 1'b1;
      rem_sum    = {1'b0, rem_ff} + {1'b0, minor_mag_ff};
      last       = step_next >= {1'b0, major_len_ff};
      emit       = step_en && (item.opcode == lpr_pkg::OP_ADVANCE) && active_ff;

      pix_valid       = emit;
      pix.pixel_x     = major_is_x_ff ? major_c : minor_c;
      pix.pixel_y     = major_is_x_ff ? minor_c : major_c;
      pix.pixel_color = color_ff;
      pix.last_pixel  = last;
   end

   // Next state: load replaces the line, advance walks it
   always_comb begin
      origin_x_in   = origin_x_ff;
      origin_y_in   = origin_y_ff;
      major_len_in  = major_len_ff;
      minor_mag_in  = minor_mag_ff;
      step_in       = step_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      major_is_x_in = major_is_x_ff;
      major_neg_in  = major_neg_ff;
      minor_neg_in  = minor_neg_ff;
      color_in      = color_ff;
      active_in     = active_ff;
      if (step_en && (item.opcode == lpr_pkg::OP_LOAD)) begin
         origin_x_in   = item.start_x;
         origin_y_in   = item.start_y;
         color_in      = item.color;
         major_is_x_in = x_major;
         major_len_in  = ld_major_len;
         minor_mag_in  = x_major ? abs_dy : abs_dx;
         major_neg_in  = x_major ? x_neg : y_neg;
         minor_neg_in  = x_major ? y_neg : x_neg;
         step_in       = '0;
         quot_in       = '0;
         rem_in        = '0;
         active_in     = ld_major_len != '0;
      end else if (emit) begin
         if (last) begin
            active_in = 1'b0;
         end else begin
            step_in = step_next[lpr_pkg::COORD_BITS-1:0];
            if (rem_sum >= {1'b0, major_len_ff}) begin
               rem_in  = lpr_pkg::COORD_BITS'(rem_sum - {1'b0, major_len_ff});
               quot_in = quot_ff + 1'b1;
            end else begin
               rem_in  = rem_sum[lpr_pkg::COORD_BITS-1:0];
            end
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   // Line payload
   always_ff @(posedge clock) begin
      origin_x_ff   <= origin_x_in;
      origin_y_ff   <= origin_y_in;
      major_len_ff  <= major_len_in;
      minor_mag_ff  <= minor_mag_in;
      step_ff       <= step_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      major_is_x_ff <= major_is_x_in;
      major_neg_ff  <= major_neg_in;
      minor_neg_ff  <= minor_neg_in;
      color_ff      <= color_in;
   end

endmodule

`default_nettype wire
